// ===== hw/rtl/glyph_gradient_blend_core_assert.svh =====
// assertion macros shared by the glyph blend checker
// no dependencies; pulled in by include where assertions are written
`ifndef GLYPH_GRADIENT_BLEND_CORE_ASSERT_SVH
`define GLYPH_GRADIENT_BLEND_CORE_ASSERT_SVH

// implication checked in the same cycle
`define GGB_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("glyph blend check failed");

// implication checked in the next cycle
`define GGB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("glyph blend check failed");

`endif

// ===== hw/rtl/ggb_pkg.sv =====
// shared constants and types for the glyph gradient blend core
// no dependencies; used by the core and its checker
`timescale 1ns / 1ps

package ggb_pkg;

   // field widths
   localparam int CHAN_W   = 8;
   localparam int NUM_CH   = 4;
   localparam int NUM_RGB  = 3;
   localparam int PIX_W    = CHAN_W * NUM_CH;
   localparam int COV_W    = 8;
   localparam int ROW_W    = 8;
   localparam int ROWS_W   = 9;
   localparam int ALPHA_LSB = CHAN_W * NUM_RGB;

   // tallest glyph handled, taller glyphs are clamped
   localparam int MAX_GLYPH_ROWS = 256;
   localparam int ROWS_MAX_CODE  = (1 << ROWS_W) - 1;
   localparam int ROWS_CAP_INT   = (MAX_GLYPH_ROWS > ROWS_MAX_CODE) ?
                                   ROWS_MAX_CODE : MAX_GLYPH_ROWS;
   localparam logic [ROWS_W-1:0] ROWS_CAP = ROWS_W'(ROWS_CAP_INT);

   // gradient fraction 0..256
   localparam int GRAD_W = CHAN_W + 1;
   // interpolation and blend products
   localparam int PROD_W = (CHAN_W + 1) + (GRAD_W + 1);
   // alpha times coverage product
   localparam int MUL_W  = 2 * (CHAN_W + 1);

   // coverage above this replaces rgb outright
   localparam logic [COV_W-1:0] COV_FULL_LIMIT = COV_W'(254);
   localparam logic [COV_W-1:0] COV_NONE       = '0;

   // configuration registers
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = PIX_W;
   localparam logic [CSR_IDX_W-1:0] REG_COLOR_TOP    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_COLOR_BOTTOM = CSR_IDX_W'(1);
   localparam logic [PIX_W-1:0]     COLOR_RESET      = 32'hFFFF_FFFF;

   // pipeline depth in stages
   localparam int NUM_STAGES = 7;

   // transaction fields carried down the pipe
   typedef struct packed {
      logic [PIX_W-1:0] dst;
      logic [COV_W-1:0] cov;
   } item_type;

endpackage

// ===== hw/rtl/glyph_gradient_blend_core.sv =====
// glyph gradient blend core: seven stage pixel pipeline
// depends on ggb_pkg
`timescale 1ns / 1ps
//
// usage
//   req_* carries one glyph pixel per transaction: destination pixel,
//   coverage, row within the glyph and glyph height. rsp_* returns the
//   blended destination pixel, one per request, in request order.
//   a transaction moves on a rising edge with valid high and stall low.
//   csr_* writes the top and bottom gradient colors; write only while
//   the pipe is empty.
// throughput and stages
//   one pixel per cycle unless the response stalls. the stages from
//   request to response: three stages of the row/height divider (three
//   quotient bits each), then color interpolation, alpha weight and
//   blend multiply, and the output register.
// reset
//   synchronous reset empties the pipe and sets both colors to white.
// stalls
//   a stalled response holds; stages behind it keep filling bubbles, so
//   requests are taken until every stage is full.

module glyph_gradient_blend_core
   import ggb_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [PIX_W-1:0]     req_dest_pixel,
   input  logic [COV_W-1:0]     req_coverage,
   input  logic [ROW_W-1:0]     req_row_index,
   input  logic [ROWS_W-1:0]    req_glyph_rows,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [PIX_W-1:0]     rsp_blended_pixel,
   // register writes
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // one restoring division step: {quotient bit, remainder}
   function automatic logic [ROWS_W:0] div_step(input logic [ROWS_W-1:0] rem,
                                                input logic [ROWS_W-1:0] dv);
      logic [ROWS_W:0] sh;
      begin
         sh = {rem, 1'b0};
         if (sh >= {1'b0, dv}) begin
            div_step = {1'b1, ROWS_W'(sh - {1'b0, dv})};
         end else begin
            div_step = {1'b0, sh[ROWS_W-1:0]};
         end
      end
   endfunction

   // configuration registers
   logic [PIX_W-1:0] color_top_ff;
   logic [PIX_W-1:0] color_bot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_top_ff <= COLOR_RESET;
         color_bot_ff <= COLOR_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_COLOR_TOP:    color_top_ff <= csr_wdata;
            REG_COLOR_BOTTOM: color_bot_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pipeline flow control: a stage loads when empty or when it drains
   logic [NUM_STAGES:1]   valid_ff;
   logic [NUM_STAGES:1]   valid_in;
   logic [NUM_STAGES+1:1] stage_ready;

   always_comb begin
      stage_ready[NUM_STAGES+1] = !rsp_stall;
      for (int k = NUM_STAGES; k >= 1; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
   end

   always_comb begin
      valid_in[1] = stage_ready[1] ? req_valid : valid_ff[1];
      for (int k = 2; k <= NUM_STAGES; k++) begin
         if (stage_ready[k]) begin
            valid_in[k] = valid_ff[k-1];
         end else begin
            valid_in[k] = valid_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !stage_ready[1];
   assign rsp_valid = valid_ff[NUM_STAGES];

   // transaction fields travel with the valid bits
   item_type it_ff [1:NUM_STAGES-1];

   always_ff @(posedge clock) begin
      if (stage_ready[1]) begin
         it_ff[1] <= '{dst: req_dest_pixel, cov: req_coverage};
      end
      for (int k = 2; k < NUM_STAGES; k++) begin
         if (stage_ready[k]) begin
            it_ff[k] <= it_ff[k-1];
         end
      end
   end

   // stage 1: clamp height and row, top quotient bits
   logic [ROWS_W-1:0] rows_sat;
   logic [ROWS_W-1:0] div_w;
   logic [ROWS_W-1:0] row_c;
   logic [ROWS_W-1:0] rem1_in;
   logic [GRAD_W-1:0] q1_in;
   logic              zero1_in;
   logic [ROWS_W:0]   st1;
   logic [ROWS_W-1:0] rem1_ff;
   logic [ROWS_W-1:0] div1_ff;
   logic [GRAD_W-1:0] q1_ff;
   logic              zero1_ff;

   always_comb begin
      rows_sat = (req_glyph_rows > ROWS_CAP) ? ROWS_CAP : req_glyph_rows;
      zero1_in = (rows_sat < ROWS_W'(2));
      div_w    = rows_sat - ROWS_W'(1);
      row_c    = ({1'b0, req_row_index} > div_w) ? div_w : {1'b0, req_row_index};
      q1_in    = '0;
      // row never passes the divisor, so the integer part is 0 or 1
      q1_in[GRAD_W-1] = (row_c == div_w) && !zero1_in;
      rem1_in  = q1_in[GRAD_W-1] ? '0 : row_c;
      st1      = '0;
      for (int i = 0; i < 2; i++) begin
         st1 = div_step(rem1_in, div_w);
         q1_in[GRAD_W-2-i] = st1[ROWS_W];
         rem1_in = st1[ROWS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[1]) begin
         rem1_ff  <= rem1_in;
         div1_ff  <= div_w;
         q1_ff    <= q1_in;
         zero1_ff <= zero1_in;
      end
   end

   // stage 2: middle quotient bits
   logic [ROWS_W-1:0] rem2_in;
   logic [GRAD_W-1:0] q2_in;
   logic [ROWS_W:0]   st2;
   logic [ROWS_W-1:0] rem2_ff;
   logic [ROWS_W-1:0] div2_ff;
   logic [GRAD_W-1:0] q2_ff;
   logic              zero2_ff;

   always_comb begin
      rem2_in = rem1_ff;
      q2_in   = q1_ff;
      st2     = '0;
      for (int i = 0; i < 3; i++) begin
         st2 = div_step(rem2_in, div1_ff);
         q2_in[GRAD_W-4-i] = st2[ROWS_W];
         rem2_in = st2[ROWS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[2]) begin
         rem2_ff  <= rem2_in;
         div2_ff  <= div1_ff;
         q2_ff    <= q2_in;
         zero2_ff <= zero1_ff;
      end
   end

   // stage 3: low quotient bits, gradient fraction
   logic [ROWS_W-1:0] rem3_in;
   logic [GRAD_W-1:0] q3_in;
   logic [ROWS_W:0]   st3;
   logic [GRAD_W-1:0] grad_ff;

   always_comb begin
      rem3_in = rem2_ff;
      q3_in   = q2_ff;
      st3     = '0;
      for (int i = 0; i < 3; i++) begin
         st3 = div_step(rem3_in, div2_ff);
         q3_in[GRAD_W-7-i] = st3[ROWS_W];
         rem3_in = st3[ROWS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[3]) begin
         grad_ff <= zero2_ff ? '0 : q3_in;
      end
   end

   // stage 4: per channel (bottom - top) * fraction
   logic signed [CHAN_W:0]   ch_diff [NUM_CH];
   logic signed [PROD_W-1:0] ip_in   [NUM_CH];
   logic signed [PROD_W-1:0] ip_ff   [NUM_CH];
   logic [CHAN_W-1:0]        top_ff  [NUM_CH];

   always_comb begin
      for (int k = 0; k < NUM_CH; k++) begin
         ch_diff[k] = $signed({1'b0, color_bot_ff[k*CHAN_W +: CHAN_W]})
                    - $signed({1'b0, color_top_ff[k*CHAN_W +: CHAN_W]});
         ip_in[k]   = ch_diff[k] * $signed({1'b0, grad_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[4]) begin
         for (int k = 0; k < NUM_CH; k++) begin
            ip_ff[k]  <= ip_in[k];
            top_ff[k] <= color_top_ff[k*CHAN_W +: CHAN_W];
         end
      end
   end

   // stage 5: gradient color, alpha times coverage weight
   logic signed [PROD_W-1:0] src_sum [NUM_CH];
   logic [CHAN_W-1:0]        src_w   [NUM_CH];
   logic [CHAN_W:0]          alpha_x;
   logic [CHAN_W:0]          cov_x;
   logic [CHAN_W-1:0]        cov5;
   logic [MUL_W-1:0]         mulw_ff;
   logic [CHAN_W-1:0]        src5_ff [NUM_RGB];

   always_comb begin
      for (int k = 0; k < NUM_CH; k++) begin
         src_sum[k] = $signed({{(PROD_W-CHAN_W){1'b0}}, top_ff[k]}) + (ip_ff[k] >>> CHAN_W);
         src_w[k]   = src_sum[k][CHAN_W-1:0];
      end
      // widen 0..255 to 0..256
      alpha_x = {1'b0, src_w[NUM_RGB]} + (CHAN_W+1)'(src_w[NUM_RGB][CHAN_W-1]);
      cov5    = it_ff[4].cov;
      cov_x   = {1'b0, cov5} + (CHAN_W+1)'(cov5[COV_W-1]);
   end

   always_ff @(posedge clock) begin
      if (stage_ready[5]) begin
         mulw_ff <= alpha_x * cov_x;
         for (int k = 0; k < NUM_RGB; k++) begin
            src5_ff[k] <= src_w[k];
         end
      end
   end

   // stage 6: per channel (source - dest) * weight
   logic [CHAN_W:0]          weight;
   logic signed [CHAN_W:0]   bl_diff [NUM_RGB];
   logic signed [PROD_W-1:0] bp_in   [NUM_RGB];
   logic signed [PROD_W-1:0] bp_ff   [NUM_RGB];
   logic [CHAN_W-1:0]        src6_ff [NUM_RGB];

   always_comb begin
      weight = mulw_ff[2*CHAN_W:CHAN_W];
      for (int k = 0; k < NUM_RGB; k++) begin
         bl_diff[k] = $signed({1'b0, src5_ff[k]})
                    - $signed({1'b0, it_ff[5].dst[k*CHAN_W +: CHAN_W]});
         bp_in[k]   = bl_diff[k] * $signed({1'b0, weight});
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[6]) begin
         for (int k = 0; k < NUM_RGB; k++) begin
            bp_ff[k]   <= bp_in[k];
            src6_ff[k] <= src5_ff[k];
         end
      end
   end

   // stage 7: finish blend, pick by coverage, output register
   logic signed [PROD_W-1:0] bl_sum [NUM_RGB];
   logic [PIX_W-1:0]         pix_in;
   logic [PIX_W-1:0]         pix_ff;
   item_type                 it7;

   always_comb begin
      it7    = it_ff[6];
      pix_in = it7.dst;
      for (int k = 0; k < NUM_RGB; k++) begin
         bl_sum[k] = $signed({{(PROD_W-CHAN_W){1'b0}}, it7.dst[k*CHAN_W +: CHAN_W]})
                   + (bp_ff[k] >>> CHAN_W);
         if (it7.cov == COV_NONE) begin
            pix_in[k*CHAN_W +: CHAN_W] = it7.dst[k*CHAN_W +: CHAN_W];
         end else if (it7.cov > COV_FULL_LIMIT) begin
            pix_in[k*CHAN_W +: CHAN_W] = src6_ff[k];
         end else begin
            pix_in[k*CHAN_W +: CHAN_W] = bl_sum[k][CHAN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[NUM_STAGES]) begin
         pix_ff <= pix_in;
      end
   end

   assign rsp_blended_pixel = pix_ff;

endmodule

// ===== hw/rtl/ggb_checker.sv =====
// port level checks for the glyph gradient blend core, bound to the top
// depends on ggb_pkg and glyph_gradient_blend_core_assert.svh
`timescale 1ns / 1ps
`include "glyph_gradient_blend_core_assert.svh"

module ggb_checker
   import ggb_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic [PIX_W-1:0]     req_dest_pixel,
   input logic [COV_W-1:0]     req_coverage,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [PIX_W-1:0]     rsp_blended_pixel
);

   // request taken, then the response side never stalls for the pipe depth
   sequence s_flow;
      (req_valid && !req_stall && !rsp_stall) ##1 !rsp_stall ##1 !rsp_stall
         ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall;
   endsequence

   // same, for a transaction with zero coverage
   sequence s_flow_clear;
      (req_valid && !req_stall && !rsp_stall && req_coverage == COV_NONE)
         ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
         ##1 !rsp_stall ##1 !rsp_stall;
   endsequence

   // reset empties the pipe
   `GGB_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_valid)

   // a stalled response stays put
   `GGB_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && rsp_stall,
                    rsp_valid && $stable(rsp_blended_pixel))

   // destination alpha comes out after the pipe latency
   `GGB_ASSERT_NEXT(a_alpha_kept, clock, reset, s_flow,
                    rsp_valid && rsp_blended_pixel[PIX_W-1:ALPHA_LSB] ==
                    $past(req_dest_pixel[PIX_W-1:ALPHA_LSB], NUM_STAGES))

   // zero coverage passes the destination through unchanged
   `GGB_ASSERT_NEXT(a_clear_passes, clock, reset, s_flow_clear,
                    rsp_valid && rsp_blended_pixel == $past(req_dest_pixel, NUM_STAGES))

endmodule

bind glyph_gradient_blend_core ggb_checker u_ggb_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .req_dest_pixel    (req_dest_pixel),
   .req_coverage      (req_coverage),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_blended_pixel (rsp_blended_pixel)
);

// ===== verif/tb.sv =====
// self-checking testbench for glyph_gradient_blend_core: directed table, then random pixels
// depends on ggb_pkg and glyph_gradient_blend_core; expected pixels come from an internal predictor
`timescale 1ns / 1ps

module tb
   import ggb_pkg::*;
();

   localparam int LONG_HOLD = 80;
   localparam int PHASE_PIXELS = 150;
   localparam int NUM_PHASES = 6;
   localparam int NUM_DIRECTED = 22;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [PIX_W-1:0]      req_dest_pixel;
   logic [COV_W-1:0]      req_coverage;
   logic [ROW_W-1:0]      req_row_index;
   logic [ROWS_W-1:0]     req_glyph_rows;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [PIX_W-1:0]      rsp_blended_pixel;
   logic                  csr_write;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // one row of the directed table, want is only meaningful when typed is set
   typedef struct packed {
      logic [PIX_W-1:0]  dst;
      logic [COV_W-1:0]  cov;
      logic [ROW_W-1:0]  row;
      logic [ROWS_W-1:0] rows;
      logic [PIX_W-1:0]  top;
      logic [PIX_W-1:0]  bottom;
      logic              typed;
      logic [PIX_W-1:0]  want;
   } directed_row_type;

   directed_row_type directed_rows [0:NUM_DIRECTED-1] = '{
      // white gradient: full coverage paints white, no coverage leaves the pixel alone
      '{32'h1234_5678, 8'd0,   8'd0,   9'd1,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h1234_5678},
      '{32'hFFFF_FFFF, 8'd0,   8'd255, 9'd511, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
      '{32'h0000_0000, 8'd255, 8'd0,   9'd1,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h00FF_FFFF},
      '{32'hA500_0000, 8'd255, 8'd3,   9'd8,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hA5FF_FFFF},
      '{32'hFF00_0000, 8'd255, 8'd255, 9'd256, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
      '{32'h0000_0000, 8'd1,   8'd1,   9'd2,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0},
      '{32'h8080_8080, 8'd128, 8'd4,   9'd16,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0},
      '{32'hFFFF_FFFF, 8'd254, 8'd9,   9'd10,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0},
      '{32'h0000_0000, 8'd127, 8'd0,   9'd2,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0},
      // black to white: zero and one row heights, rows past the end, tall glyphs
      '{32'h1111_1111, 8'd255, 8'd0,   9'd0,   32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0},
      '{32'h2222_2222, 8'd255, 8'd5,   9'd1,   32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0},
      '{32'h3333_3333, 8'd255, 8'd255, 9'd2,   32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0},
      '{32'h4444_4444, 8'd255, 8'd255, 9'd511, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0},
      '{32'h5555_5555, 8'd255, 8'd200, 9'd257, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0},
      '{32'h6666_6666, 8'd255, 8'd128, 9'd256, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0},
      '{32'h7777_7777, 8'd255, 8'd1,   9'd3,   32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0},
      '{32'h5A5A_A5A5, 8'd200, 8'd100, 9'd256, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0},
      '{32'hFF00_0000, 8'd1,   8'd255, 9'd256, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0},
      // white to black with partial and full coverage
      '{32'h0000_0000, 8'd254, 8'd0,   9'd256, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 32'h0},
      '{32'hFFFF_FFFF, 8'd254, 8'd255, 9'd256, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 32'h0},
      '{32'h9ABC_DEF0, 8'd64,  8'd7,   9'd9,   32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 32'h0},
      '{32'h00FF_FFFF, 8'd255, 8'd10,  9'd20,  32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 32'h0}
   };

   // shadow copy of the color registers
   logic [PIX_W-1:0] top_color;
   logic [PIX_W-1:0] bottom_color;

   logic [PIX_W-1:0] pending_pixels [$];
   int mismatch_count = 0;
   int pixels_checked = 0;
   int color_settings = 1;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_epoch = 0;

   glyph_gradient_blend_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_dest_pixel    (req_dest_pixel),
      .req_coverage      (req_coverage),
      .req_row_index     (req_row_index),
      .req_glyph_rows    (req_glyph_rows),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_blended_pixel (rsp_blended_pixel),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

   // expected blend of one glyph pixel under the given gradient colors
   function automatic logic [PIX_W-1:0] blend_pixel(
      input logic [PIX_W-1:0]  dst,
      input logic [COV_W-1:0]  cov,
      input logic [ROW_W-1:0]  row,
      input logic [ROWS_W-1:0] rows,
      input logic [PIX_W-1:0]  top,
      input logic [PIX_W-1:0]  bottom
   );
      int height, r, frac, t, b, src_alpha, cov_w, weight, d, k;
      int src [4];
      logic [PIX_W-1:0] res;
      height = rows;
      if (height > MAX_GLYPH_ROWS) height = MAX_GLYPH_ROWS;
      r = row;
      frac = 0;
      if (height >= 2) begin
         if (r > height - 1) r = height - 1;
         frac = (r * 256) / (height - 1);
      end
      // per channel interpolation, index 0 is alpha
      for (k = 0; k < NUM_CH; k++) begin
         t = top[ALPHA_LSB - CHAN_W * k +: CHAN_W];
         b = bottom[ALPHA_LSB - CHAN_W * k +: CHAN_W];
         src[k] = t + (((b - t) * frac) >>> 8);
      end
      src_alpha = src[0] + (src[0] >> 7);
      if (cov > COV_FULL_LIMIT) begin
         res = {dst[PIX_W-1:ALPHA_LSB], 8'(src[1]), 8'(src[2]), 8'(src[3])};
      end else if (cov != COV_NONE) begin
         cov_w = int'(cov) + (int'(cov) >> 7);
         weight = (src_alpha * cov_w) >> 8;
         res = dst;
         for (k = 1; k < NUM_CH; k++) begin
            d = dst[ALPHA_LSB - CHAN_W * k +: CHAN_W];
            d = d + (((src[k] - d) * weight) >>> 8);
            res[ALPHA_LSB - CHAN_W * k +: CHAN_W] = 8'(d);
         end
      end else begin
         res = dst;
      end
      return res;
   endfunction

   // offer one pixel, called and returning at a rising edge
   task automatic send_pixel(
      input logic [PIX_W-1:0]  dst,
      input logic [COV_W-1:0]  cov,
      input logic [ROW_W-1:0]  row,
      input logic [ROWS_W-1:0] rows,
      input logic              typed,
      input logic [PIX_W-1:0]  want
   );
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_dest_pixel <= dst;
      req_coverage   <= cov;
      req_row_index  <= row;
      req_glyph_rows <= rows;
      // the transaction moves at the edge after a negedge with stall low
      forever begin
         @(negedge clock);
         if (!req_stall) break;
      end
      pending_pixels.push_back(typed ? want :
                               blend_pixel(dst, cov, row, rows, top_color, bottom_color));
      @(posedge clock);
   endtask

   // stop offering and wait for every expected pixel plus the pipe depth
   task automatic drain_pipe();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (NUM_STAGES + 2) @(posedge clock);
   endtask

   task automatic write_color(input logic [CSR_IDX_W-1:0] idx, input logic [PIX_W-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == REG_COLOR_TOP) top_color = val;
      else bottom_color = val;
      @(posedge clock);
   endtask

   task automatic set_colors(input logic [PIX_W-1:0] top, input logic [PIX_W-1:0] bottom);
      drain_pipe();
      write_color(REG_COLOR_TOP, top);
      write_color(REG_COLOR_BOTTOM, bottom);
      color_settings++;
   endtask

   // random pixel biased toward the coverage and height corners
   task automatic send_random_pixel();
      logic [PIX_W-1:0]  dst;
      logic [COV_W-1:0]  cov;
      logic [ROW_W-1:0]  row;
      logic [ROWS_W-1:0] rows;
      int last_row;
      dst = $urandom;
      case ($urandom_range(9))
         0: cov = COV_NONE;
         1: cov = COV_FULL_LIMIT + 8'd1;
         2: cov = COV_FULL_LIMIT;
         3: cov = 8'd1;
         default: cov = COV_W'($urandom_range(255));
      endcase
      case ($urandom_range(15))
         0: rows = 9'd0;
         1: rows = 9'd1;
         2: rows = ROWS_W'($urandom_range(MAX_GLYPH_ROWS + 1, ROWS_MAX_CODE));
         3: rows = ROWS_W'(MAX_GLYPH_ROWS);
         default: rows = ROWS_W'($urandom_range(2, MAX_GLYPH_ROWS - 1));
      endcase
      last_row = (rows > MAX_GLYPH_ROWS) ? MAX_GLYPH_ROWS - 1 : int'(rows) - 1;
      if (rows < 2 || $urandom_range(4) == 0) row = ROW_W'($urandom_range(255));
      else row = ROW_W'($urandom_range(last_row));
      send_pixel(dst, cov, row, rows, 1'b0, '0);
   endtask

   // response side: random stalls, long holds on request, in-order check
   initial begin
      int seen_epoch;
      int hold_left;
      logic [PIX_W-1:0] want;
      seen_epoch = 0;
      hold_left = 0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (hold_epoch != seen_epoch) begin
            seen_epoch = hold_epoch;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
         @(negedge clock);
         if (rsp_valid && !rsp_stall) begin
            if (pending_pixels.size() == 0) begin
               $display("%0t: blended pixel %08h with no pending transaction",
                        $time, rsp_blended_pixel);
               mismatch_count++;
            end else begin
               want = pending_pixels.pop_front();
               pixels_checked++;
               if (rsp_blended_pixel !== want) begin
                  $display("%0t: blended pixel mismatch, expected %08h, got %08h",
                           $time, want, rsp_blended_pixel);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // stimulus
   initial begin
      int i, phase;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_dest_pixel = '0;
      req_coverage   = '0;
      req_row_index  = '0;
      req_glyph_rows = '0;
      rsp_stall      = 1'b0;
      csr_write      = 1'b0;
      csr_index      = REG_COLOR_TOP;
      csr_wdata      = '0;
      top_color      = COLOR_RESET;
      bottom_color   = COLOR_RESET;
      send_idle_pct  = 7;
      recv_idle_pct  = 54;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table, colors change only with the pipe empty
      for (i = 0; i < NUM_DIRECTED; i++) begin
         if (directed_rows[i].top != top_color || directed_rows[i].bottom != bottom_color)
            set_colors(directed_rows[i].top, directed_rows[i].bottom);
         send_pixel(directed_rows[i].dst, directed_rows[i].cov, directed_rows[i].row,
                    directed_rows[i].rows, directed_rows[i].typed, directed_rows[i].want);
      end

      // random phases: color setting per phase, idle pattern per pair of phases
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: set_colors(32'h0000_0000, 32'h0000_0000);
            1: set_colors(32'hFF00_0000, 32'h00FF_FFFF);
            2: set_colors(32'hFFFF_FFFF, 32'h0000_0000);
            default: set_colors($urandom, $urandom);
         endcase
         if (phase < 2) begin
            send_idle_pct = 7;
            recv_idle_pct = 54;
         end else if (phase < 4) begin
            send_idle_pct = 54;
            recv_idle_pct = 7;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (i = 0; i < PHASE_PIXELS; i++) begin
            // long output hold while input keeps coming, fills the pipe
            if ((phase == 0 || phase == 4) && i == 40) hold_epoch++;
            // sender waits for the pipe to empty mid-phase
            if (phase == 3 && i == 75) drain_pipe();
            send_random_pixel();
         end
      end

      drain_pipe();
      $display("checked %0d blended pixels over %0d gradient color settings,",
               pixels_checked, color_settings);
      $display("with idle and stall mixes, long output holds and a full pipe");
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
